FILE: rtl/triangle_circumcircle_unit_defines.svh
// Assertion macros shared by the triangle circumcircle RTL.
`ifndef TRIANGLE_CIRCUMCIRCLE_UNIT_DEFINES_SVH
`define TRIANGLE_CIRCUMCIRCLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcc: same-cycle check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcc: next-cycle check failed");
`else
`define TCC_ASSERT_IMP(lbl, ante, cons)
`define TCC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/tcc_pkg.sv
// Shared constants and types of the triangle circumcircle unit.
package tcc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  // quotient bits of the center and radius dividers; larger quotients clamp
  localparam int CEN_QUO_BITS   = 42;
  localparam int RAD_QUO_BITS   = 32;
  localparam int OUT_BITS       = 32;

  // per-stage control handed to each pipeline section
  typedef struct packed {
    logic en;   // advance all stages
    logic vld;  // word entering stage 0
  } tcc_ctl_t;

endpackage

FILE: rtl/tcc_geom.sv
// Geometry front end: determinant, center numerators and squared numerator sum.
module tcc_geom import tcc_pkg::*; #(
  parameter int CB = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcc_ctl_t             ctl,
  input  logic signed [CB-1:0] ax_i,
  input  logic signed [CB-1:0] ay_i,
  input  logic signed [CB-1:0] bx_i,
  input  logic signed [CB-1:0] by_i,
  input  logic signed [CB-1:0] cx_i,
  input  logic signed [CB-1:0] cy_i,
  output logic                 vld_o,
  output logic signed [CB-1:0] ax_o,
  output logic signed [CB-1:0] ay_o,
  output logic [3*CB+2:0]      nxm_o,
  output logic [3*CB+2:0]      nym_o,
  output logic                 nxneg_o,
  output logic                 nyneg_o,
  output logic [2*CB+2:0]      den_o,
  output logic                 deg_o,
  output logic [6*CB+6:0]      ssq_o
);

  localparam int NST = 10;
  localparam int NMW = 3*CB+3;
  localparam int H   = (NMW+1)/2;
  localparam int HB  = NMW-H;
  localparam int SQW = 2*NMW;

  logic [NST-1:0]          v_r;
  logic signed [CB-1:0]    ax_r [NST];
  logic signed [CB-1:0]    ay_r [NST];
  logic signed [CB-1:0]    bx0_r, by0_r, cx0_r, cy0_r;
  logic signed [CB:0]      bx_r [1:3];
  logic signed [CB:0]      by_r [1:3];
  logic signed [CB:0]      cx_r [1:3];
  logic signed [CB:0]      cy_r [1:3];
  logic signed [2*CB+1:0]  pbc2_r, pcb2_r, pbb2_r, pyb2_r, pcc2_r, pyc2_r;
  logic signed [2*CB+2:0]  d3_r;
  logic [2*CB+1:0]         mb3_r, mc3_r;
  logic signed [3*CB+3:0]  p1_4_r, p2_4_r, p3_4_r, p4_4_r;
  logic [2*CB+2:0]         den_r [4:9];
  logic                    dneg_r [4:5];
  logic                    deg_r [4:9];
  logic signed [3*CB+4:0]  nx5_r, ny5_r;
  logic [NMW-1:0]          nxm_r [6:9];
  logic [NMW-1:0]          nym_r [6:9];
  logic                    nxn_r [6:9];
  logic                    nyn_r [6:9];
  logic [2*HB-1:0]         xhh7_r, yhh7_r;
  logic [NMW-1:0]          xhl7_r, yhl7_r;
  logic [2*H-1:0]          xll7_r, yll7_r;
  logic [SQW-1:0]          sx8_r, sy8_r;
  logic [SQW:0]            s9_r;

  logic signed [2*CB+2:0]  absd;
  logic signed [3*CB+4:0]  nxa, nya;

  assign absd = d3_r[2*CB+2]  ? -d3_r  : d3_r;
  assign nxa  = nx5_r[3*CB+4] ? -nx5_r : nx5_r;
  assign nya  = ny5_r[3*CB+4] ? -ny5_r : ny5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ctl.en) begin
      v_r <= {v_r[NST-2:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      // capture
      ax_r[0] <= ax_i;
      ay_r[0] <= ay_i;
      bx0_r   <= bx_i;
      by0_r   <= by_i;
      cx0_r   <= cx_i;
      cy0_r   <= cy_i;
      for (int k = 1; k < NST; k++) begin
        ax_r[k] <= ax_r[k-1];
        ay_r[k] <= ay_r[k-1];
      end
      // move the origin to vertex A
      bx_r[1] <= (CB+1)'(bx0_r) - (CB+1)'(ax_r[0]);
      by_r[1] <= (CB+1)'(by0_r) - (CB+1)'(ay_r[0]);
      cx_r[1] <= (CB+1)'(cx0_r) - (CB+1)'(ax_r[0]);
      cy_r[1] <= (CB+1)'(cy0_r) - (CB+1)'(ay_r[0]);
      for (int k = 2; k <= 3; k++) begin
        bx_r[k] <= bx_r[k-1];
        by_r[k] <= by_r[k-1];
        cx_r[k] <= cx_r[k-1];
        cy_r[k] <= cy_r[k-1];
      end
      // cross and square terms
      pbc2_r <= bx_r[1] * cy_r[1];
      pcb2_r <= cx_r[1] * by_r[1];
      pbb2_r <= bx_r[1] * bx_r[1];
      pyb2_r <= by_r[1] * by_r[1];
      pcc2_r <= cx_r[1] * cx_r[1];
      pyc2_r <= cy_r[1] * cy_r[1];
      // determinant and squared edge lengths
      d3_r  <= (2*CB+3)'(pbc2_r) - (2*CB+3)'(pcb2_r);
      mb3_r <= $unsigned(pbb2_r) + $unsigned(pyb2_r);
      mc3_r <= $unsigned(pcc2_r) + $unsigned(pyc2_r);
      // numerator products
      p1_4_r <= signed'({1'b0, mb3_r}) * cy_r[3];
      p2_4_r <= signed'({1'b0, mc3_r}) * by_r[3];
      p3_4_r <= signed'({1'b0, mc3_r}) * bx_r[3];
      p4_4_r <= signed'({1'b0, mb3_r}) * cx_r[3];
      den_r[4]  <= {absd[2*CB+1:0], 1'b0};
      dneg_r[4] <= d3_r[2*CB+2];
      deg_r[4]  <= (d3_r == '0);
      for (int k = 5; k <= 9; k++) begin
        den_r[k] <= den_r[k-1];
        deg_r[k] <= deg_r[k-1];
      end
      dneg_r[5] <= dneg_r[4];
      nx5_r <= (3*CB+5)'(p1_4_r) - (3*CB+5)'(p2_4_r);
      ny5_r <= (3*CB+5)'(p3_4_r) - (3*CB+5)'(p4_4_r);
      // magnitude and quotient sign
      nxm_r[6] <= nxa[NMW-1:0];
      nym_r[6] <= nya[NMW-1:0];
      nxn_r[6] <= nx5_r[3*CB+4] ^ dneg_r[5];
      nyn_r[6] <= ny5_r[3*CB+4] ^ dneg_r[5];
      for (int k = 7; k <= 9; k++) begin
        nxm_r[k] <= nxm_r[k-1];
        nym_r[k] <= nym_r[k-1];
        nxn_r[k] <= nxn_r[k-1];
        nyn_r[k] <= nyn_r[k-1];
      end
      // squares from half-width partial products
      xhh7_r <= nxm_r[6][NMW-1:H] * nxm_r[6][NMW-1:H];
      xhl7_r <= nxm_r[6][NMW-1:H] * nxm_r[6][H-1:0];
      xll7_r <= nxm_r[6][H-1:0] * nxm_r[6][H-1:0];
      yhh7_r <= nym_r[6][NMW-1:H] * nym_r[6][NMW-1:H];
      yhl7_r <= nym_r[6][NMW-1:H] * nym_r[6][H-1:0];
      yll7_r <= nym_r[6][H-1:0] * nym_r[6][H-1:0];
      sx8_r <= (SQW'(xhh7_r) << (2*H)) + (SQW'(xhl7_r) << (H+1)) + SQW'(xll7_r);
      sy8_r <= (SQW'(yhh7_r) << (2*H)) + (SQW'(yhl7_r) << (H+1)) + SQW'(yll7_r);
      s9_r  <= (SQW+1)'(sx8_r) + (SQW+1)'(sy8_r);
    end
  end

  assign vld_o   = v_r[NST-1];
  assign ax_o    = ax_r[NST-1];
  assign ay_o    = ay_r[NST-1];
  assign nxm_o   = nxm_r[9];
  assign nym_o   = nym_r[9];
  assign nxneg_o = nxn_r[9];
  assign nyneg_o = nyn_r[9];
  assign den_o   = den_r[9];
  assign deg_o   = deg_r[9];
  assign ssq_o   = s9_r;

endmodule

FILE: rtl/tcc_div.sv
// Pipelined restoring divider, one quotient bit per stage, clamps to all ones.
module tcc_div import tcc_pkg::*; #(
  parameter int NW  = 60,
  parameter int DW  = 35,
  parameter int QB  = CEN_QUO_BITS,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tcc_ctl_t       ctl,
  input  logic [NW-1:0]  num_i,
  input  logic [DW-1:0]  den_i,
  input  logic [SBW-1:0] sb_i,
  output logic           out_v_o,
  output logic [QB-1:0]  quo_o,
  output logic           exact_o,
  output logic [SBW-1:0] sb_o
);

  localparam int NX = (NW > QB) ? NW : QB+1;
  localparam int HW = NX-QB;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [NX-1:0]  numx;
  logic [HW-1:0]  hi;
  logic           sat_in;

  logic [QB:0]    v_r;
  logic [DW-1:0]  rem_r [0:QB];
  logic [QB-1:0]  quo_r [0:QB];
  logic           sat_r [0:QB];
  logic [SBW-1:0] sb_r  [0:QB];
  logic [QB-1:0]  low_r [0:QB-1];
  logic [DW-1:0]  den_r [0:QB-1];

  logic [DW:0]    t_c  [1:QB];
  logic           ge_c [1:QB];

  assign numx   = NX'(num_i);
  assign hi     = numx[NX-1:QB];
  // quotient would not fit: clamp
  assign sat_in = CW'(hi) >= CW'(den_i);

  always_comb begin
    for (int k = 1; k <= QB; k++) begin
      t_c[k]  = {rem_r[k-1], low_r[k-1][QB-1]};
      ge_c[k] = t_c[k] >= {1'b0, den_r[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ctl.en) begin
      v_r <= {v_r[QB-1:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rem_r[0] <= DW'(hi);
      low_r[0] <= numx[QB-1:0];
      quo_r[0] <= '0;
      sat_r[0] <= sat_in;
      den_r[0] <= den_i;
      sb_r[0]  <= sb_i;
      for (int k = 1; k <= QB; k++) begin
        rem_r[k] <= ge_c[k] ? DW'(t_c[k] - {1'b0, den_r[k-1]}) : DW'(t_c[k]);
        quo_r[k] <= {quo_r[k-1][QB-2:0], ge_c[k]};
        sat_r[k] <= sat_r[k-1];
        sb_r[k]  <= sb_r[k-1];
      end
      for (int k = 1; k < QB; k++) begin
        low_r[k] <= low_r[k-1] << 1;
        den_r[k] <= den_r[k-1];
      end
    end
  end

  assign out_v_o = v_r[QB];
  assign quo_o   = sat_r[QB] ? '1 : quo_r[QB];
  assign exact_o = !sat_r[QB] && (rem_r[QB] == '0);
  assign sb_o    = sb_r[QB];

endmodule

FILE: rtl/tcc_sqrt.sv
// Pipelined integer square root, one root bit per stage, truncating.
module tcc_sqrt import tcc_pkg::*; #(
  parameter int RW  = 120,
  parameter int SBW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tcc_ctl_t        ctl,
  input  logic [RW-1:0]   rad_i,
  input  logic [SBW-1:0]  sb_i,
  output logic            out_v_o,
  output logic [RW/2-1:0] root_o,
  output logic [SBW-1:0]  sb_o
);

  localparam int RH = RW/2;

  logic [RH:0]    v_r;
  logic [RW-1:0]  rad_r  [0:RH-1];
  logic [RH:0]    rem_r  [0:RH];
  logic [RH-1:0]  root_r [0:RH];
  logic [SBW-1:0] sb_r   [0:RH];

  logic [RH+2:0]  t_c  [1:RH];
  logic [RH+2:0]  tr_c [1:RH];
  logic           ge_c [1:RH];

  always_comb begin
    for (int k = 1; k <= RH; k++) begin
      t_c[k]  = {rem_r[k-1], rad_r[k-1][RW-1:RW-2]};
      tr_c[k] = (RH+3)'({root_r[k-1], 2'b01});
      ge_c[k] = t_c[k] >= tr_c[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ctl.en) begin
      v_r <= {v_r[RH-1:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rad_r[0]  <= rad_i;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      sb_r[0]   <= sb_i;
      for (int k = 1; k <= RH; k++) begin
        rem_r[k]  <= ge_c[k] ? (RH+1)'(t_c[k] - tr_c[k]) : (RH+1)'(t_c[k]);
        root_r[k] <= {root_r[k-1][RH-2:0], ge_c[k]};
        sb_r[k]   <= sb_r[k-1];
      end
      for (int k = 1; k < RH; k++) begin
        rad_r[k] <= rad_r[k-1] << 2;
      end
    end
  end

  assign out_v_o = v_r[RH];
  assign root_o  = root_r[RH];
  assign sb_o    = sb_r[RH];

endmodule

FILE: rtl/triangle_circumcircle_unit.sv
// Top level of the triangle circumcircle unit: pipeline sections and output buffer.
//
//  channel | handshake            | word
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | in_ax, in_ay, in_bx, in_by, in_cx, in_cy
//  out     | out_valid/ out_ready | out_center_x, out_center_y, out_radius,
//          |                      | out_degenerate
//
//  One word per clock enters and leaves while the skid register is empty.
//  The radius square root, one root bit per stage over RH = 3*COORD_BITS +
//  FRAC_BITS + 4 root bits, is the longest pipeline section.
//  Reset clears only valid bits; in_ready is high right after reset.
//  A stalled output parks one word in a skid register; the pipeline freezes
//  while that register is full and in_ready drops.
`include "triangle_circumcircle_unit_defines.svh"
module triangle_circumcircle_unit import tcc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_ax,
  input  logic signed [COORD_BITS-1:0] in_ay,
  input  logic signed [COORD_BITS-1:0] in_bx,
  input  logic signed [COORD_BITS-1:0] in_by,
  input  logic signed [COORD_BITS-1:0] in_cx,
  input  logic signed [COORD_BITS-1:0] in_cy,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OUT_BITS-1:0]   out_center_x,
  output logic signed [OUT_BITS-1:0]   out_center_y,
  output logic [OUT_BITS-1:0]          out_radius,
  output logic                         out_degenerate
);

  // numerator magnitude, denominator, squared sum, root radicand widths
  localparam int NMW  = 3*COORD_BITS+3;
  localparam int DENW = 2*COORD_BITS+3;
  localparam int SW   = 2*NMW+1;
  localparam int RW   = SW+2*FRAC_BITS+1;
  localparam int RH   = RW/2;
  localparam int CNW  = NMW+FRAC_BITS;
  localparam int CBW  = COORD_BITS+1;
  // center and radius branch lengths; the center branch is padded to match
  localparam int CEN_LAT = CEN_QUO_BITS+2;
  localparam int RAD_LAT = RH+1+RAD_QUO_BITS+1;
  localparam int DLY     = RAD_LAT-CEN_LAT;
  localparam int TW = ((CEN_QUO_BITS > COORD_BITS+FRAC_BITS) ?
                       CEN_QUO_BITS : COORD_BITS+FRAC_BITS) + 2;
  localparam logic signed [TW-1:0] MAXV = TW'(2147483647);
  localparam logic signed [TW-1:0] MINV = ~MAXV;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] center_x;
    logic signed [OUT_BITS-1:0] center_y;
    logic [OUT_BITS-1:0]        radius;
    logic                       degenerate;
  } tcc_word_t;

  // floor(base + signed quotient) in fixed point, clamped to 32 bits
  function automatic logic signed [OUT_BITS-1:0] cen_sat(
    input logic [CEN_QUO_BITS-1:0]      q,
    input logic                         ex,
    input logic                         ng,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [TW-1:0] qs;
    logic signed [TW-1:0] off;
    logic signed [TW-1:0] tot;
    qs  = signed'(TW'(q));
    off = ng ? (-qs - signed'(TW'(!ex))) : qs;
    tot = (TW'(b) <<< FRAC_BITS) + off;
    if (tot > MAXV) begin
      tot = MAXV;
    end else if (tot < MINV) begin
      tot = MINV;
    end
    return tot[OUT_BITS-1:0];
  endfunction

  logic      en;
  tcc_ctl_t  in_ctl, mid_ctl, rdv_ctl;

  // geometry outputs
  logic                         g_v;
  logic signed [COORD_BITS-1:0] g_ax, g_ay;
  logic [NMW-1:0]               g_nxm, g_nym;
  logic                         g_nxneg, g_nyneg;
  logic [DENW-1:0]              g_den;
  logic                         g_deg;
  logic [SW-1:0]                g_ssq;

  // dividers and root
  logic                    dx_v;
  logic [CEN_QUO_BITS-1:0] dx_q, dy_q;
  logic                    dx_ex, dy_ex;
  logic [CBW-1:0]          dx_sb, dy_sb;
  logic                    sq_v;
  logic [RH-1:0]           sq_root;
  logic [DENW:0]           sq_sb;
  logic                    rd_v;
  logic [RAD_QUO_BITS-1:0] rd_q;
  logic                    rd_sb;

  // center finish and delay line
  logic                       cf_v_r;
  logic signed [OUT_BITS-1:0] cf_x_r, cf_y_r;
  logic [DLY-1:0]             dl_v_r;
  logic signed [OUT_BITS-1:0] dl_x_r [DLY];
  logic signed [OUT_BITS-1:0] dl_y_r [DLY];

  // output buffer
  tcc_word_t pipe_w, out_w_r, skid_w_r;
  logic      out_v_r, skid_v_r, out_v_nxt, skid_v_nxt;
  logic      ld_out, ld_skid, sel_skid;

  // the whole pipeline moves while the skid register is empty
  assign en       = !skid_v_r;
  assign in_ready = en;

  assign in_ctl.en   = en;
  assign in_ctl.vld  = in_valid;
  assign mid_ctl.en  = en;
  assign mid_ctl.vld = g_v;
  assign rdv_ctl.en  = en;
  assign rdv_ctl.vld = sq_v;

  tcc_geom #(.CB(COORD_BITS)) u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (in_ctl),
    .ax_i    (in_ax),
    .ay_i    (in_ay),
    .bx_i    (in_bx),
    .by_i    (in_by),
    .cx_i    (in_cx),
    .cy_i    (in_cy),
    .vld_o   (g_v),
    .ax_o    (g_ax),
    .ay_o    (g_ay),
    .nxm_o   (g_nxm),
    .nym_o   (g_nym),
    .nxneg_o (g_nxneg),
    .nyneg_o (g_nyneg),
    .den_o   (g_den),
    .deg_o   (g_deg),
    .ssq_o   (g_ssq)
  );

  // center x offset = Nx * 2^F / (2|D|)
  tcc_div #(.NW(CNW), .DW(DENW), .QB(CEN_QUO_BITS), .SBW(CBW)) u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mid_ctl),
    .num_i   (CNW'(g_nxm) << FRAC_BITS),
    .den_i   (g_den),
    .sb_i    ({g_nxneg, g_ax}),
    .out_v_o (dx_v),
    .quo_o   (dx_q),
    .exact_o (dx_ex),
    .sb_o    (dx_sb)
  );

  tcc_div #(.NW(CNW), .DW(DENW), .QB(CEN_QUO_BITS), .SBW(CBW)) u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mid_ctl),
    .num_i   (CNW'(g_nym) << FRAC_BITS),
    .den_i   (g_den),
    .sb_i    ({g_nyneg, g_ay}),
    .out_v_o (),
    .quo_o   (dy_q),
    .exact_o (dy_ex),
    .sb_o    (dy_sb)
  );

  // radius = floor(sqrt(S * 2^2F)) / (2|D|), truncated
  tcc_sqrt #(.RW(RW), .SBW(DENW+1)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mid_ctl),
    .rad_i   (RW'(g_ssq) << (2*FRAC_BITS)),
    .sb_i    ({g_deg, g_den}),
    .out_v_o (sq_v),
    .root_o  (sq_root),
    .sb_o    (sq_sb)
  );

  tcc_div #(.NW(RH), .DW(DENW), .QB(RAD_QUO_BITS), .SBW(1)) u_div_r (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (rdv_ctl),
    .num_i   (sq_root),
    .den_i   (sq_sb[DENW-1:0]),
    .sb_i    (sq_sb[DENW]),
    .out_v_o (rd_v),
    .quo_o   (rd_q),
    .exact_o (),
    .sb_o    (rd_sb)
  );

  // add the vertex A base, floor negative quotients, clamp; then delay to line up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cf_v_r <= 1'b0;
      dl_v_r <= '0;
    end else if (en) begin
      cf_v_r <= dx_v;
      dl_v_r <= {dl_v_r[DLY-2:0], cf_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cf_x_r    <= cen_sat(dx_q, dx_ex, dx_sb[CBW-1], dx_sb[COORD_BITS-1:0]);
      cf_y_r    <= cen_sat(dy_q, dy_ex, dy_sb[CBW-1], dy_sb[COORD_BITS-1:0]);
      dl_x_r[0] <= cf_x_r;
      dl_y_r[0] <= cf_y_r;
      for (int k = 1; k < DLY; k++) begin
        dl_x_r[k] <= dl_x_r[k-1];
        dl_y_r[k] <= dl_y_r[k-1];
      end
    end
  end

  // collinear vertices: flag and zero everything else
  always_comb begin
    pipe_w.degenerate = rd_sb;
    pipe_w.center_x   = rd_sb ? '0 : dl_x_r[DLY-1];
    pipe_w.center_y   = rd_sb ? '0 : dl_y_r[DLY-1];
    pipe_w.radius     = rd_sb ? '0 : rd_q;
  end

  // output register with one skid slot
  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    ld_out     = 1'b0;
    ld_skid    = 1'b0;
    sel_skid   = 1'b0;
    if (skid_v_r) begin
      if (out_ready) begin
        ld_out     = 1'b1;
        sel_skid   = 1'b1;
        skid_v_nxt = 1'b0;
      end
    end else if (rd_v) begin
      if (out_v_r && !out_ready) begin
        ld_skid    = 1'b1;
        skid_v_nxt = 1'b1;
      end else begin
        ld_out    = 1'b1;
        out_v_nxt = 1'b1;
      end
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_w_r <= sel_skid ? skid_w_r : pipe_w;
    end
    if (ld_skid) begin
      skid_w_r <= pipe_w;
    end
  end

  assign out_valid      = out_v_r;
  assign out_center_x   = out_w_r.center_x;
  assign out_center_y   = out_w_r.center_y;
  assign out_radius     = out_w_r.radius;
  assign out_degenerate = out_w_r.degenerate;

  // center and radius branches must deliver the same word together
  `TCC_ASSERT_IMP(a_branch_align, 1'b1, dl_v_r[DLY-1] == rd_v)
  // a parked word always sits behind a full output register
  `TCC_ASSERT_IMP(a_skid_behind_out, skid_v_r, out_v_r)
  // the skid slot fills only when the output was stalled
  `TCC_ASSERT_IMP(a_skid_fill, $rose(skid_v_r), $past(out_v_r && !out_ready))
  // degenerate words carry zeros
  `TCC_ASSERT_IMP(a_degen_zero, out_v_r && out_w_r.degenerate,
                  out_w_r.center_x == '0 && out_w_r.center_y == '0 &&
                  out_w_r.radius == '0)

endmodule

FILE: tb/tb_top.sv
// Testbench for triangle_circumcircle_unit: random and directed triangles, checked in order.
`timescale 1ns / 100ps
module tb_top;
  import tcc_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 3000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES = 150;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [127:0] wide_t;
  typedef logic [127:0] uwide_t;

  typedef struct {
    coord_t ax, ay, bx, by, cx, cy;
  } tri_word_t;

  typedef struct {
    logic signed [OUT_BITS-1:0] center_x;
    logic signed [OUT_BITS-1:0] center_y;
    logic [OUT_BITS-1:0]        radius;
    logic                       degenerate;
  } circle_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  coord_t in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
  logic signed [OUT_BITS-1:0] out_center_x, out_center_y;
  logic [OUT_BITS-1:0] out_radius;
  logic out_degenerate;

  circle_t pending_circles[$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit sender_gaps = 1;     // random gaps between input words
  bit receiver_gaps = 1;   // random stalls on the output side
  int hold_off_left = 0;   // long receiver hold-off, counted down below

  triangle_circumcircle_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_ax(in_ax), .in_ay(in_ay), .in_bx(in_bx), .in_by(in_by),
    .in_cx(in_cx), .in_cy(in_cy),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_center_x(out_center_x), .out_center_y(out_center_y),
    .out_radius(out_radius), .out_degenerate(out_degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Circumcircle predictor. Everything is exact wide integer math relative
  // to vertex A; center is floored, radius truncated, both saturated.
  // ---------------------------------------------------------------------
  function automatic logic [127:0] isqrt128(input logic [127:0] v);
    logic [127:0] root, cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= v) root = cand;
    end
    return root;
  endfunction

  // base + num/den, floored, in FB fraction bits, clamped to 32-bit signed
  function automatic logic signed [OUT_BITS-1:0] center_axis(input wide_t base,
                                                             input wide_t num_in,
                                                             input wide_t den_in);
    wide_t num, den, quo, total;
    num = num_in <<< FB;
    den = den_in;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    quo = num / den;
    if (num < 0 && quo * den != num) quo = quo - 1;
    total = (base <<< FB) + quo;
    if (total > wide_t'(32'sh7fffffff)) total = wide_t'(32'sh7fffffff);
    if (total < -wide_t'(64'sh80000000)) total = -wide_t'(64'sh80000000);
    return total[OUT_BITS-1:0];
  endfunction

  function automatic circle_t predict_circle(input tri_word_t t);
    circle_t c;
    wide_t bx, by, cx, cy, det, mb, mc, nx, ny, den;
    logic [127:0] root, quo;
    bx = wide_t'(t.bx) - wide_t'(t.ax);
    by = wide_t'(t.by) - wide_t'(t.ay);
    cx = wide_t'(t.cx) - wide_t'(t.ax);
    cy = wide_t'(t.cy) - wide_t'(t.ay);
    det = bx * cy - cx * by;
    c = '{default: '0};
    if (det == 0) begin
      // collinear or coincident vertices: no circle, flag and zero the rest
      c.degenerate = 1'b1;
      return c;
    end
    mb = bx * bx + by * by;
    mc = cx * cx + cy * cy;
    nx = mb * cy - mc * by;
    ny = mc * bx - mb * cx;
    den = det <<< 1;
    c.center_x = center_axis(wide_t'(t.ax), nx, den);
    c.center_y = center_axis(wide_t'(t.ay), ny, den);
    // largest r with r*|den| <= sqrt((nx^2 + ny^2) * 2^(2*FB))
    root = isqrt128(uwide_t'(nx * nx + ny * ny) << (2 * FB));
    quo = root / uwide_t'(den < 0 ? -den : den);
    c.radius = (quo > 128'hffff_ffff) ? 32'hffff_ffff : quo[31:0];
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: optional random gap, then offer the word until it is taken.
  // ---------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_triangle(input tri_word_t t);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ax <= t.ax; in_ay <= t.ay; in_bx <= t.bx;
    in_by <= t.by; in_cx <= t.cx; in_cy <= t.cy;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_circles.insert(pending_circles.size(), predict_circle(t));
  endtask

  // drop valid so the last word is not taken twice
  task automatic park_sender();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    park_sender();
    while (pending_circles.size() != 0) @(posedge clk);
  endtask

  function automatic tri_word_t make_tri(input int ax, ay, bx, by, cx, cy);
    tri_word_t t;
    t.ax = coord_t'(ax); t.ay = coord_t'(ay); t.bx = coord_t'(bx);
    t.by = coord_t'(by); t.cx = coord_t'(cx); t.cy = coord_t'(cy);
    return t;
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  function automatic int rand_span(input int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Mix of shapes: full-range, small, collinear, nearly collinear.
  function automatic tri_word_t random_triangle();
    tri_word_t t;
    int kind, ox, oy, dx, dy, k1, k2;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      t = make_tri(rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord());
    end else if (kind < 70) begin
      ox = rand_span(30000); oy = rand_span(30000);
      t = make_tri(ox, oy, ox + rand_span(300), oy + rand_span(300),
                   ox + rand_span(300), oy + rand_span(300));
    end else begin
      ox = rand_span(20000); oy = rand_span(20000);
      dx = rand_span(100); dy = rand_span(100);
      k1 = rand_span(50); k2 = rand_span(50);
      t = make_tri(ox, oy, ox + k1 * dx, oy + k1 * dy, ox + k2 * dx, oy + k2 * dy);
      // nudge one vertex off the line for a giant, saturating circle
      if (kind >= 85) t.cy = t.cy + coord_t'($urandom_range(1, 2));
    end
    return t;
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: random stalls, or a forced long hold-off when requested.
  // ---------------------------------------------------------------------
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (!receiver_gaps) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(0, 2);
    end
  end

  // ---------------------------------------------------------------------
  // Result check: each accepted word against the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    circle_t exp_c;
    if (rst_n && out_valid && out_ready) begin
      if (pending_circles.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: cx=%0d cy=%0d r=%0d deg=%0b",
                   out_center_x, out_center_y, out_radius, out_degenerate);
      end else begin
        exp_c = pending_circles.pop_front();
        if (out_center_x !== exp_c.center_x || out_center_y !== exp_c.center_y ||
            out_radius !== exp_c.radius || out_degenerate !== exp_c.degenerate) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: exp cx=%0d cy=%0d r=%0d deg=%0b, ",
                      "got cx=%0d cy=%0d r=%0d deg=%0b"},
                     exp_c.center_x, exp_c.center_y, exp_c.radius, exp_c.degenerate,
                     out_center_x, out_center_y, out_radius, out_degenerate);
        end
      end
    end
  end

  // watchdog: ends the run if no word moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed();
    tri_word_t t;
    send_triangle(make_tri(0, 0, 4, 0, 0, 3));                  // right triangle
    send_triangle(make_tri(0, 0, 3, 0, 0, -5));                 // negative center y
    send_triangle(make_tri(1, 1, 2, 2, 3, 3));                  // collinear
    send_triangle(make_tri(7, -7, 7, -7, 7, -7));               // coincident
    send_triangle(make_tri(5, 5, 5, 5, 9, 1));                  // two vertices equal
    send_triangle(make_tri(0, 0, 1, 0, 0, 1));                  // tiny, fractional center
    send_triangle(make_tri(0, 0, 0, 1, 1, 0));                  // flipped orientation
    send_triangle(make_tri(-32768, -32768, 32767, -32768, -32768, 32767));
    send_triangle(make_tri(32767, 32767, -32768, 32767, 32767, -32768));
    send_triangle(make_tri(-32768, 32767, 32767, -32768, -32768, -32768));
    send_triangle(make_tri(-32768, -32768, 32767, 32767, 32767, 32766)); // giant circle
    send_triangle(make_tri(-32768, -32768, 32767, 32767, 32766, 32767));
    send_triangle(make_tri(-32768, 0, 32767, 0, 0, 1));         // flat, huge radius
    send_triangle(make_tri(-32768, 0, 32767, 0, 0, -1));
    send_triangle(make_tri(-32768, -32768, 32767, 32767, 0, 0)); // collinear, full span
    send_triangle(make_tri(-1, -1, 1, -1, 0, 1));               // center below origin
    send_triangle(make_tri(-3, -3, -1, -3, -3, -2));            // negative center
    t = make_tri(-21846, 21845, 21845, -21846, -1, 0);          // alternating bit patterns
    send_triangle(t);
    send_triangle(make_tri(32767, 0, 0, 32767, -32768, 0));
  endtask

  task automatic test_random(input int count);
    repeat (count) send_triangle(random_triangle());
  endtask

  // receiver holds off while words keep coming, so the pipe fills and stalls
  task automatic test_output_stall();
    wait_drained();
    @(negedge clk);
    hold_off_left = 400;
    sender_gaps = 0;
    test_random(200);
    sender_gaps = 1;
  endtask

  // sender waits for every result, then restarts from an empty pipe
  task automatic test_drain_pause();
    test_random(30);
    wait_drained();
    test_random(30);
  endtask

  // full rate on both sides
  task automatic test_streaming();
    sender_gaps = 0;
    receiver_gaps = 0;
    test_random(100);
    sender_gaps = 1;
    receiver_gaps = 1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    {in_ax, in_ay, in_bx, in_by, in_cx, in_cy} = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(200);
    test_output_stall();
    test_drain_pause();
    test_streaming();
    test_random(200);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: triangle_circumcircle_unit.f
+incdir+rtl
rtl/tcc_pkg.sv
rtl/tcc_geom.sv
rtl/tcc_div.sv
rtl/tcc_sqrt.sv
rtl/triangle_circumcircle_unit.sv
tb/tb_top.sv
